FILE: design/ntc_adc_to_temperature_assert.svh
// assertion macros for the ntc adc to temperature block
// used by files that check their own logic; no other dependencies
`ifndef NTC_ADC_TO_TEMPERATURE_ASSERT_SVH
`define NTC_ADC_TO_TEMPERATURE_ASSERT_SVH

// same-cycle implication
`define NTC_ASSERT_IMPL(lbl, clk, rst, ante, cons) \
  lbl: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) \
    else $error("ntc_adc_to_temperature: assertion failed");

// next-cycle implication
`define NTC_ASSERT_NEXT(lbl, clk, rst, ante, cons) \
  lbl: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) \
    else $error("ntc_adc_to_temperature: assertion failed");

`endif

FILE: design/ntc_pkg.sv
// shared types, constants, thermistor rom and microcode program
// no dependencies
package ntc_pkg;

  localparam int TABLE_SIZE = 148;
  localparam int ROM_WORDS  = 148;
  localparam int ROM_LEN    = (TABLE_SIZE < ROM_WORDS) ?
                              ((TABLE_SIZE < 2) ? 2 : TABLE_SIZE) : ROM_WORDS;
  localparam int IDX_W      = $clog2(ROM_LEN);
  localparam int ROM_W      = 12;
  localparam int ADC_W      = 16;
  localparam int TEMP_W     = 12;
  localparam int BASE_DEG   = 18;
  localparam int NUM_W      = 19;  // (diff * 100 + 5) for a 12-bit diff
  localparam int DVS_W      = 16;  // 10 * gap for a 12-bit gap
  localparam int QUO_W      = 4;   // quotient stays below ten

  localparam logic signed [TEMP_W-1:0] TEMP_MIN = TEMP_W'(-(BASE_DEG * 10));
  localparam logic signed [TEMP_W-1:0] TEMP_MAX = TEMP_W'((ROM_LEN - 1 - BASE_DEG) * 10);

  // status codes
  localparam logic [2:0] ST_OK    = 3'd0;
  localparam logic [2:0] ST_SHORT = 3'd1;
  localparam logic [2:0] ST_OPEN  = 3'd2;
  localparam logic [2:0] ST_BELOW = 3'd3;
  localparam logic [2:0] ST_ABOVE = 3'd4;

  // register indexes
  localparam logic REG_SHORT = 1'b0;
  localparam logic REG_OPEN  = 1'b1;

  localparam logic [ROM_W-1:0] NTC_ROM [ROM_WORDS] = '{
    12'd122,  12'd129,  12'd137,  12'd145,  12'd153,  12'd161,  12'd170,  12'd180,
    12'd189,  12'd200,  12'd210,  12'd221,  12'd233,  12'd245,  12'd258,  12'd271,
    12'd284,  12'd298,  12'd313,  12'd328,  12'd344,  12'd361,  12'd378,  12'd395,
    12'd413,  12'd432,  12'd452,  12'd472,  12'd493,  12'd514,  12'd536,  12'd559,
    12'd582,  12'd606,  12'd631,  12'd656,  12'd682,  12'd709,  12'd740,  12'd768,
    12'd799,  12'd824,  12'd854,  12'd890,  12'd926,  12'd953,  12'd989,  12'd1014,
    12'd1044, 12'd1077, 12'd1112, 12'd1147, 12'd1182, 12'd1218, 12'd1254, 12'd1290,
    12'd1331, 12'd1366, 12'd1410, 12'd1440, 12'd1478, 12'd1516, 12'd1554, 12'd1593,
    12'd1632, 12'd1670, 12'd1709, 12'd1748, 12'd1787, 12'd1826, 12'd1865, 12'd1904,
    12'd1943, 12'd1981, 12'd2012, 12'd2058, 12'd2096, 12'd2134, 12'd2160, 12'd2209,
    12'd2246, 12'd2282, 12'd2319, 12'd2355, 12'd2390, 12'd2426, 12'd2460, 12'd2495,
    12'd2529, 12'd2562, 12'd2595, 12'd2628, 12'd2660, 12'd2692, 12'd2723, 12'd2754,
    12'd2784, 12'd2813, 12'd2843, 12'd2871, 12'd2899, 12'd2927, 12'd2954, 12'd2981,
    12'd3007, 12'd3032, 12'd3057, 12'd3082, 12'd3106, 12'd3129, 12'd3152, 12'd3175,
    12'd3197, 12'd3218, 12'd3240, 12'd3260, 12'd3280, 12'd3300, 12'd3319, 12'd3338,
    12'd3356, 12'd3374, 12'd3392, 12'd3409, 12'd3426, 12'd3442, 12'd3458, 12'd3473,
    12'd3489, 12'd3503, 12'd3518, 12'd3532, 12'd3545, 12'd3559, 12'd3572, 12'd3585,
    12'd3597, 12'd3609, 12'd3621, 12'd3632, 12'd3643, 12'd3654, 12'd3665, 12'd3675,
    12'd3685, 12'd3695, 12'd3705, 12'd3714
  };

  function automatic logic [ROM_W-1:0] rom_word(input logic [IDX_W-1:0] idx);
    logic [ROM_W-1:0] w;
    w = '0;
    if (int'(idx) < ROM_WORDS) begin
      w = NTC_ROM[idx];
    end
    return w;
  endfunction

  // (idx - 18) * 10
  function automatic logic signed [TEMP_W-1:0] entry_tenths(input logic [IDX_W-1:0] idx);
    logic signed [TEMP_W-1:0] t;
    t = $signed(TEMP_W'(idx)) - TEMP_W'(BASE_DEG);
    return (t <<< 3) + (t <<< 1);
  endfunction

  // datapath operations
  typedef logic [2:0] op_t;
  localparam op_t OP_LOAD   = 3'd0;
  localparam op_t OP_CHECK  = 3'd1;
  localparam op_t OP_SEARCH = 3'd2;
  localparam op_t OP_FETCH  = 3'd3;
  localparam op_t OP_PREP   = 3'd4;
  localparam op_t OP_DIV    = 3'd5;
  localparam op_t OP_FINISH = 3'd6;
  localparam op_t OP_EMIT   = 3'd7;

  // jump conditions
  typedef logic [2:0] cond_t;
  localparam cond_t J_NEVER   = 3'd0;
  localparam cond_t J_NOSTART = 3'd1;
  localparam cond_t J_FAULT   = 3'd2;
  localparam cond_t J_MORE    = 3'd3;
  localparam cond_t J_DIRECT  = 3'd4;
  localparam cond_t J_BUSY    = 3'd5;

  localparam int STEP_W = 4;
  typedef logic [STEP_W-1:0] step_t;
  localparam step_t S_IDLE   = 4'd0;
  localparam step_t S_CHECK  = 4'd1;
  localparam step_t S_SEARCH = 4'd2;
  localparam step_t S_FETCH  = 4'd3;
  localparam step_t S_PREP   = 4'd4;
  localparam step_t S_DIV3   = 4'd5;
  localparam step_t S_DIV2   = 4'd6;
  localparam step_t S_DIV1   = 4'd7;
  localparam step_t S_DIV0   = 4'd8;
  localparam step_t S_FINISH = 4'd9;
  localparam step_t S_DONE   = 4'd10;
  localparam step_t S_LAST   = S_DONE;

  typedef struct packed {
    logic       rdy;
    op_t        op;
    logic [1:0] sh;
    cond_t      jc;
    step_t      target;
  } cw_t;

  typedef struct packed {
    logic start;
    logic fault;
    logic more;
    logic direct;
    logic busy;
  } flags_t;

  function automatic cw_t mk_cw(input logic rdy, input op_t op, input logic [1:0] sh,
                                input cond_t jc, input step_t target);
    cw_t c;
    c.rdy    = rdy;
    c.op     = op;
    c.sh     = sh;
    c.jc     = jc;
    c.target = target;
    return c;
  endfunction

  // microcode program
  function automatic cw_t ucode(input step_t step);
    cw_t c;
    unique case (step)
      S_IDLE:   c = mk_cw(1'b1, OP_LOAD,   2'd0, J_NOSTART, S_IDLE);
      S_CHECK:  c = mk_cw(1'b0, OP_CHECK,  2'd0, J_FAULT,   S_DONE);
      S_SEARCH: c = mk_cw(1'b0, OP_SEARCH, 2'd0, J_MORE,    S_SEARCH);
      S_FETCH:  c = mk_cw(1'b0, OP_FETCH,  2'd0, J_NEVER,   S_IDLE);
      S_PREP:   c = mk_cw(1'b0, OP_PREP,   2'd0, J_DIRECT,  S_DONE);
      S_DIV3:   c = mk_cw(1'b0, OP_DIV,    2'd3, J_NEVER,   S_IDLE);
      S_DIV2:   c = mk_cw(1'b0, OP_DIV,    2'd2, J_NEVER,   S_IDLE);
      S_DIV1:   c = mk_cw(1'b0, OP_DIV,    2'd1, J_NEVER,   S_IDLE);
      S_DIV0:   c = mk_cw(1'b0, OP_DIV,    2'd0, J_NEVER,   S_IDLE);
      S_FINISH: c = mk_cw(1'b0, OP_FINISH, 2'd0, J_NEVER,   S_IDLE);
      S_DONE:   c = mk_cw(1'b0, OP_EMIT,   2'd0, J_BUSY,    S_DONE);
      default:  c = mk_cw(1'b0, OP_EMIT,   2'd0, J_NEVER,   S_IDLE);
    endcase
    return c;
  endfunction

endpackage

FILE: design/ntc_seq.sv
// microcode sequencer: step counter, program rom and conditional jumps
// depends on ntc_pkg
module ntc_seq import ntc_pkg::*; (
  input  logic   clk,
  input  logic   rst,
  input  flags_t flags,
  output cw_t    cw,
  output step_t  step
);

  step_t step_next;
  logic  taken;

  assign cw = ucode(step);

  always_comb begin
    unique case (cw.jc)
      J_NEVER:   taken = 1'b0;
      J_NOSTART: taken = !flags.start;
      J_FAULT:   taken = flags.fault;
      J_MORE:    taken = flags.more;
      J_DIRECT:  taken = flags.direct;
      J_BUSY:    taken = flags.busy;
      default:   taken = 1'b0;
    endcase
    if (taken) begin
      step_next = cw.target;
    end else if (step == S_LAST) begin
      step_next = S_IDLE;
    end else begin
      step_next = step + step_t'(1);
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      step <= S_IDLE;
    end else begin
      step <= step_next;
    end
  end

endmodule

FILE: design/ntc_dp.sv
// datapath: thresholds, search bounds, serial divider and output register
// depends on ntc_pkg; driven by the control word of ntc_seq
module ntc_dp import ntc_pkg::*; (
  input  logic                     clk,
  input  logic                     rst,
  input  cw_t                      cw,
  input  logic                     cfg_we,
  input  logic                     cfg_index,
  input  logic [ADC_W-1:0]         cfg_data,
  input  logic                     in_valid,
  input  logic [ADC_W-1:0]         adc_value,
  input  logic                     out_ready,
  output logic                     out_valid,
  output logic [2:0]               status,
  output logic signed [TEMP_W-1:0] temperature_tenths,
  output flags_t                   flags
);

  logic [ROM_W-1:0]         short_thr;
  logic [ADC_W-1:0]         open_thr;
  logic [ADC_W-1:0]         v;
  logic [IDX_W-1:0]         lo, hi;
  logic [ROM_W-1:0]         a, b;
  logic [NUM_W-1:0]         rem;
  logic [DVS_W-1:0]         dvs;
  logic [QUO_W-1:0]         q;
  logic [2:0]               stat;
  logic signed [TEMP_W-1:0] temp;

  logic [2:0]       fault_code;
  logic [IDX_W:0]   mid_sum;
  logic [IDX_W-1:0] mid;
  logic [IDX_W-1:0] span;
  logic             go_up;
  logic [ROM_W-1:0] diff, gap;
  logic [NUM_W-1:0] num, trial;
  logic             emit;

  // fault bands, first match wins
  always_comb begin
    priority if (v <= ADC_W'(short_thr)) begin
      fault_code = ST_SHORT;
    end else if (v >= open_thr) begin
      fault_code = ST_OPEN;
    end else if (v < ADC_W'(rom_word('0))) begin
      fault_code = ST_BELOW;
    end else if (v > ADC_W'(rom_word(IDX_W'(ROM_LEN - 1)))) begin
      fault_code = ST_ABOVE;
    end else begin
      fault_code = ST_OK;
    end
  end

  assign mid_sum = {1'b0, lo} + {1'b0, hi};
  assign mid     = mid_sum[IDX_W:1];
  assign span    = hi - lo;
  assign go_up   = (v <= ADC_W'(rom_word(hi))) && (v > ADC_W'(rom_word(mid)));

  assign diff  = v[ROM_W-1:0] - a;
  assign gap   = b - a;
  assign num   = (NUM_W'(diff) << 6) + (NUM_W'(diff) << 5) + (NUM_W'(diff) << 2) + NUM_W'(5);
  assign trial = NUM_W'(dvs) << cw.sh;

  assign flags.start  = in_valid && cw.rdy;
  assign flags.fault  = (fault_code != ST_OK);
  assign flags.more   = (span > IDX_W'(1));
  assign flags.direct = (v == ADC_W'(a)) || (v == ADC_W'(b)) || (b <= a);
  assign flags.busy   = out_valid && !out_ready;

  assign emit = (cw.op == OP_EMIT) && !flags.busy;

  always_ff @(posedge clk) begin
    if (rst) begin
      short_thr <= ROM_W'(15);
      open_thr  <= ADC_W'(4096);
    end else if (cfg_we) begin
      unique case (cfg_index)
        REG_SHORT: short_thr <= cfg_data[ROM_W-1:0];
        REG_OPEN:  open_thr  <= cfg_data;
        default:   ;
      endcase
    end
  end

  always_ff @(posedge clk) begin
    unique case (cw.op)
      OP_LOAD: begin
        if (flags.start) begin
          v  <= adc_value;
          lo <= '0;
          hi <= IDX_W'(ROM_LEN - 1);
        end
      end
      OP_CHECK: begin
        stat <= fault_code;
        temp <= '0;
      end
      OP_SEARCH: begin
        if (flags.more) begin
          if (go_up) begin
            lo <= mid;
          end else begin
            hi <= mid;
          end
        end
      end
      OP_FETCH: begin
        a <= rom_word(lo);
        b <= rom_word(hi);
      end
      OP_PREP: begin
        rem <= num;
        dvs <= (DVS_W'(gap) << 3) + (DVS_W'(gap) << 1);
        q   <= '0;
        if (v != ADC_W'(a) && v == ADC_W'(b)) begin
          temp <= entry_tenths(hi);
        end else begin
          temp <= entry_tenths(lo);
        end
      end
      OP_DIV: begin
        if (rem >= trial) begin
          rem      <= rem - trial;
          q[cw.sh] <= 1'b1;
        end
      end
      OP_FINISH: begin
        temp <= temp + $signed(TEMP_W'(q));
      end
      OP_EMIT: begin
        if (emit) begin
          status             <= stat;
          temperature_tenths <= temp;
        end
      end
      default: ;
    endcase
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid <= 1'b0;
    end else if (emit) begin
      out_valid <= 1'b1;
    end else if (out_ready) begin
      out_valid <= 1'b0;
    end
  end

endmodule

FILE: design/ntc_adc_to_temperature.sv
// top level of the ntc reading to temperature converter
// depends on ntc_pkg, ntc_seq, ntc_dp and ntc_adc_to_temperature_assert.svh
//
// usage:
//   input channel in_valid/in_ready carries one adc_value request; the output
//   channel out_valid/out_ready returns status and temperature_tenths
//   (tenths of a degree, zero whenever status is a fault code)
//   thresholds are written through cfg_we/cfg_index/cfg_data while idle
// sequence:
//   one request at a time; a fault reading goes from the check step straight
//   to the emit step; an in-range reading first runs the binary search over
//   the rom (one probe per cycle) and then, unless it hits a bracketing word
//   exactly, the 4-step restoring divide
// stalls:
//   the result sits in an output register; the next request is taken while
//   it waits, and the sequencer holds on its emit step only if the output
//   register is still full
// reset:
//   rst (synchronous) returns the sequencer to idle, drops out_valid and
//   sets short_threshold to 15 and open_threshold to 4096
`include "ntc_adc_to_temperature_assert.svh"

module ntc_adc_to_temperature import ntc_pkg::*; (
  input  logic                     clk,
  input  logic                     rst,
  // configuration writes
  input  logic                     cfg_we,
  input  logic                     cfg_index,
  input  logic [ADC_W-1:0]         cfg_data,
  // reading request
  input  logic                     in_valid,
  output logic                     in_ready,
  input  logic [ADC_W-1:0]         adc_value,
  // result
  output logic                     out_valid,
  input  logic                     out_ready,
  output logic [2:0]               status,
  output logic signed [TEMP_W-1:0] temperature_tenths
);

  cw_t    cw;
  flags_t flags;
  step_t  step;

  // sequencer walks the microcode program
  ntc_seq u_seq (
    .clk   (clk),
    .rst   (rst),
    .flags (flags),
    .cw    (cw),
    .step  (step)
  );

  // datapath executes one control word per cycle
  ntc_dp u_dp (
    .clk                (clk),
    .rst                (rst),
    .cw                 (cw),
    .cfg_we             (cfg_we),
    .cfg_index          (cfg_index),
    .cfg_data           (cfg_data),
    .in_valid           (in_valid),
    .adc_value          (adc_value),
    .out_ready          (out_ready),
    .out_valid          (out_valid),
    .status             (status),
    .temperature_tenths (temperature_tenths),
    .flags              (flags)
  );

  // only the idle step takes a request
  assign in_ready = cw.rdy;

  // a request is never taken twice in a row
  `NTC_ASSERT_NEXT(a_one_at_a_time, clk, rst, in_valid && in_ready, !in_ready)
  // fault results carry no temperature
  `NTC_ASSERT_IMPL(a_fault_zero, clk, rst, out_valid && status != ST_OK,
                   temperature_tenths == '0)
  // status codes stay within the defined set
  `NTC_ASSERT_IMPL(a_status_range, clk, rst, out_valid, status <= ST_ABOVE)
  // good results stay within the table span
  `NTC_ASSERT_IMPL(a_temp_range, clk, rst, out_valid && status == ST_OK,
                   temperature_tenths >= TEMP_MIN && temperature_tenths <= TEMP_MAX)
  // a result appears only from the emit step
  `NTC_ASSERT_IMPL(a_emit_source, clk, rst, $rose(out_valid), $past(step) == S_DONE)

endmodule

FILE: bench/ntc_adc_to_temperature_test.sv
// self-checking bench for ntc_adc_to_temperature: directed corners, then random readings
// depends on ntc_pkg and the ntc_adc_to_temperature design files
module ntc_adc_to_temperature_test import ntc_pkg::*;;

  timeunit 1ns;
  timeprecision 1ps;

  localparam logic [11:0] SHORT_AT_RESET = 12'd15;
  localparam logic [15:0] OPEN_AT_RESET  = 16'd4096;
  localparam int          STALL_LIMIT    = 3000;  // cycles with no handshake at all
  localparam int          SETTLE_CYCLES  = 24;    // settle margin after the last result

  // corner readings, all checked under the reset thresholds
  localparam logic [15:0] CORNER_READINGS [24] = '{
    16'd0,     16'd15,    16'd16,    16'd121,   16'd122,   16'd123,
    16'd125,   16'd129,   16'd180,   16'd1440,  16'd1441,  16'd2000,
    16'd3710,  16'd3713,  16'd3714,  16'd3715,  16'd4095,  16'd4096,
    16'd4097,  16'd65535, 16'h8000,  16'h5555,  16'hAAAA,  16'd300
  };

  // one expected status and temperature, with the reading that caused it
  typedef struct {
    logic [15:0]        reading;
    logic [2:0]         st;
    logic signed [11:0] tenths;
  } temp_result_t;

  // thresholds mirror and queue of pending conversions
  class temp_scoreboard;
    logic [11:0]  short_thr = SHORT_AT_RESET;
    logic [15:0]  open_thr  = OPEN_AT_RESET;
    temp_result_t pending_q[$];
    int           errors    = 0;

    function void set_thresholds(logic [11:0] sh, logic [15:0] op);
      short_thr = sh;
      open_thr  = op;
    endfunction

    // fault bands first, then rom search with truncating interpolation
    function temp_result_t convert_reading(logic [15:0] v);
      temp_result_t r;
      int rd, lo, hi, mid, a, b, tn;
      rd = int'(v);
      tn = 0;
      r.reading = v;
      if (rd <= int'(short_thr)) begin
        r.st = ST_SHORT;
      end else if (rd >= int'(open_thr)) begin
        r.st = ST_OPEN;
      end else if (rd < int'(NTC_ROM[0])) begin
        r.st = ST_BELOW;
      end else if (rd > int'(NTC_ROM[ROM_LEN-1])) begin
        r.st = ST_ABOVE;
      end else begin
        r.st = ST_OK;
        lo = 0;
        hi = ROM_LEN - 1;
        while (hi - lo > 1) begin
          mid = (lo + hi) / 2;
          if (rd <= int'(NTC_ROM[hi]) && rd > int'(NTC_ROM[mid])) lo = mid;
          else hi = mid;
        end
        a = int'(NTC_ROM[lo]);
        b = int'(NTC_ROM[hi]);
        if (rd == a) tn = (lo - BASE_DEG) * 10;
        else if (rd == b) tn = (hi - BASE_DEG) * 10;
        else if (b <= a) tn = (lo - BASE_DEG) * 10;
        else tn = (lo - BASE_DEG) * 10 + ((rd - a) * 100 + 5) / 10 / (b - a);
      end
      r.tenths = tn[11:0];
      return r;
    endfunction

    function void note_reading(logic [15:0] v);
      pending_q.push_back(convert_reading(v));
    endfunction

    function void check_result(logic [2:0] st, logic signed [11:0] tenths);
      temp_result_t e;
      if (pending_q.size() == 0) begin
        $error("unexpected result: status %0d temperature_tenths %0d", st, tenths);
        errors++;
        return;
      end
      e = pending_q.pop_front();
      if (st !== e.st) begin
        $error("status (reading %0d): expected %0d, got %0d", e.reading, e.st, st);
        errors++;
      end
      if (tenths !== e.tenths) begin
        $error("temperature_tenths (reading %0d): expected %0d, got %0d",
               e.reading, e.tenths, tenths);
        errors++;
      end
    endfunction

    function int outstanding();
      return pending_q.size();
    endfunction
  endclass

  logic               clk = 1'b0;
  logic               rst;
  logic               cfg_we;
  logic               cfg_index;
  logic [ADC_W-1:0]   cfg_data;
  logic               in_valid;
  logic               in_ready;
  logic [ADC_W-1:0]   adc_value;
  logic               out_valid;
  logic               out_ready;
  logic [2:0]         status;
  logic signed [11:0] temperature_tenths;

  temp_scoreboard sb;
  int             send_idle_pct  = 0;   // chance per cycle that no request is offered
  int             recv_stall_pct = 0;   // chance per cycle that out_ready is low
  int             quiet_cycles   = 0;

  ntc_adc_to_temperature dut (
    .clk                (clk),
    .rst                (rst),
    .cfg_we             (cfg_we),
    .cfg_index          (cfg_index),
    .cfg_data           (cfg_data),
    .in_valid           (in_valid),
    .in_ready           (in_ready),
    .adc_value          (adc_value),
    .out_valid          (out_valid),
    .out_ready          (out_ready),
    .status             (status),
    .temperature_tenths (temperature_tenths)
  );

  always #5 clk = ~clk;

  // result side: check on each accepted result, then pick the next ready
  always @(posedge clk) begin
    if (!rst && out_valid && out_ready) begin
      sb.check_result(status, temperature_tenths);
    end
    out_ready <= !rst && ($urandom_range(99) >= recv_stall_pct);
  end

  // watchdog: too long without any request or result moving
  always @(posedge clk) begin
    if ((in_valid && in_ready) || (out_valid && out_ready)) begin
      quiet_cycles <= 0;
    end else begin
      quiet_cycles <= quiet_cycles + 1;
    end
    if (quiet_cycles >= STALL_LIMIT) begin
      $display("RESULT: ERROR");
      $finish;
    end
  end

  // offer one request after a random idle gap and hold it until taken
  task automatic send_reading(input logic [15:0] v);
    while ($urandom_range(99) < send_idle_pct) begin
      in_valid <= 1'b0;
      @(posedge clk);
    end
    in_valid  <= 1'b1;
    adc_value <= v;
    @(posedge clk);
    while (!in_ready) @(posedge clk);
    sb.note_reading(v);
  endtask

  // wait until every result is back, then let the sequencer settle
  task automatic drain_results();
    while (sb.outstanding() != 0) @(posedge clk);
    repeat (SETTLE_CYCLES) @(posedge clk);
  endtask

  // both registers on back-to-back cycles; junk above bit 11 of the short value
  task automatic write_thresholds(input logic [11:0] sh, input logic [15:0] op);
    logic [3:0] junk;
    junk = 4'($urandom);
    cfg_we    <= 1'b1;
    cfg_index <= REG_SHORT;
    cfg_data  <= {junk, sh};
    @(posedge clk);
    cfg_index <= REG_OPEN;
    cfg_data  <= op;
    @(posedge clk);
    cfg_we <= 1'b0;
    sb.set_thresholds(sh, op);
  endtask

  // mostly in-table readings, exact rom words and their neighbors, threshold edges,
  // and some full-width noise so every input bit toggles
  function automatic logic [15:0] pick_reading();
    int pick;
    int k;
    pick = $urandom_range(99);
    if (pick < 40) begin
      return 16'($urandom_range(NTC_ROM[ROM_LEN-1], NTC_ROM[0]));
    end else if (pick < 60) begin
      k = $urandom_range(ROM_LEN - 1);
      return 16'(int'(NTC_ROM[k]) + $urandom_range(2) - 1);
    end else if (pick < 70) begin
      if ($urandom_range(1)) return 16'(int'(sb.short_thr) + $urandom_range(2) - 1);
      else return 16'(int'(sb.open_thr) + $urandom_range(2) - 1);
    end else if (pick < 80) begin
      return 16'($urandom_range(4095));
    end else begin
      return 16'($urandom);
    end
  endfunction

  task automatic run_phase(input bit new_cfg, input logic [11:0] sh, input logic [15:0] op,
                           input int send_pct, input int recv_pct, input int n);
    drain_results();
    if (new_cfg) write_thresholds(sh, op);
    send_idle_pct  = send_pct;
    recv_stall_pct = recv_pct;
    repeat (n) send_reading(pick_reading());
    in_valid <= 1'b0;
  endtask

  initial begin
    sb = new;
    rst       <= 1'b1;
    cfg_we    <= 1'b0;
    cfg_index <= REG_SHORT;
    cfg_data  <= '0;
    in_valid  <= 1'b0;
    adc_value <= '0;
    repeat (8) @(posedge clk);
    rst <= 1'b0;

    // corners under reset thresholds: every fault band, first and last word,
    // exact entries, interpolation and high input bits
    send_idle_pct  = 7;
    recv_stall_pct = 55;
    foreach (CORNER_READINGS[i]) send_reading(CORNER_READINGS[i]);
    in_valid <= 1'b0;

    // sender mostly busy, receiver stalling often
    run_phase(1'b0, SHORT_AT_RESET, OPEN_AT_RESET, 7, 55, 70);
    run_phase(1'b1, 12'd0, 16'd65535, 7, 55, 90);
    // overlapping bands: short wins up to 4095, open above
    run_phase(1'b1, 12'd4095, 16'd0, 55, 7, 60);
    run_phase(1'b1, 12'd200, 16'd3000, 55, 7, 90);
    // no idling on either side
    run_phase(1'b1, 12'($urandom), 16'($urandom), 0, 0, 80);
    run_phase(1'b1, 12'($urandom_range(300)), 16'($urandom_range(65535, 3000)), 0, 0, 80);
    run_phase(1'b1, SHORT_AT_RESET, OPEN_AT_RESET, 0, 0, 80);

    drain_results();
    if (sb.errors == 0 && sb.outstanding() == 0) begin
      $display("RESULT: OK");
    end else begin
      $display("RESULT: ERROR");
    end
    $finish;
  end

endmodule

FILE: sim.f
+incdir+design
design/ntc_pkg.sv
design/ntc_seq.sv
design/ntc_dp.sv
design/ntc_adc_to_temperature.sv
bench/ntc_adc_to_temperature_test.sv
